@@ design/c80se_pkg.sv @@
// Shared types, opcode patterns and helpers for the 8080 subset execute block.
package c80se_pkg;

  typedef struct packed {
    logic [7:0] func;
    logic [7:0] imm_low;
    logic [7:0] imm_high;
    logic [7:0] mem_byte;
  } instr_t;

  typedef struct packed {
    logic [15:0] pc;
    logic [15:0] sp;
    logic [7:0]  a;
    logic [7:0]  b;
    logic [7:0]  c;
    logic [7:0]  d;
    logic [7:0]  e;
    logic [7:0]  h;
    logic [7:0]  l;
    logic [3:0]  flags;
  } state_t;

  typedef struct packed {
    logic       mem_write;
    logic [7:0] mem_data;
    logic       unimplemented;
  } exec_t;

  localparam int unsigned FLAG_CY = 0;
  localparam int unsigned FLAG_P  = 1;
  localparam int unsigned FLAG_Z  = 2;
  localparam int unsigned FLAG_S  = 3;

  localparam logic [1:0] RP_BC = 2'd0;
  localparam logic [1:0] RP_DE = 2'd1;
  localparam logic [1:0] RP_HL = 2'd2;
  localparam logic [1:0] RP_SP = 2'd3;

  localparam logic [2:0] OPD_B = 3'd0;
  localparam logic [2:0] OPD_C = 3'd1;
  localparam logic [2:0] OPD_D = 3'd2;
  localparam logic [2:0] OPD_E = 3'd3;
  localparam logic [2:0] OPD_H = 3'd4;
  localparam logic [2:0] OPD_L = 3'd5;
  localparam logic [2:0] OPD_M = 3'd6;
  localparam logic [2:0] OPD_A = 3'd7;

  localparam logic [1:0] CC_Z  = 2'd0;
  localparam logic [1:0] CC_CY = 2'd1;
  localparam logic [1:0] CC_P  = 2'd2;
  localparam logic [1:0] CC_S  = 2'd3;

  localparam logic [7:0] OP_ADI     = 8'hc6;
  localparam logic [7:0] OP_ACI     = 8'hce;
  localparam logic [7:0] OP_SUI     = 8'hd6;
  localparam logic [7:0] OP_JMP     = 8'hc3;
  localparam logic [7:0] OP_JMP_ALT = 8'hcb;

  localparam logic [7:0] PAT_NOP    = 8'b00??_?000;
  localparam logic [7:0] PAT_INX    = 8'b00??_0011;
  localparam logic [7:0] PAT_DCX    = 8'b00??_1011;
  localparam logic [7:0] PAT_DAD    = 8'b00??_1001;
  localparam logic [7:0] PAT_INRDCR = 8'b00??_?10?;
  localparam logic [7:0] PAT_ALU    = 8'b100?_????;
  localparam logic [7:0] PAT_JCC    = 8'b11??_?010;

  function automatic logic [3:0] zsp_of(input logic [7:0] r);
    logic [3:0] f;
    f         = '0;
    f[FLAG_P] = ~^r;
    f[FLAG_Z] = (r == 8'h00);
    f[FLAG_S] = r[7];
    return f;
  endfunction

endpackage

@@ design/c80se_in_if.sv @@
// Instruction channel: opcode, two following bytes and the byte at HL.
interface c80se_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] func;
  logic [7:0] imm_low;
  logic [7:0] imm_high;
  logic [7:0] mem_byte;

  modport source (output valid, output func, output imm_low, output imm_high,
                  output mem_byte, input ready);
  modport sink   (input valid, input func, input imm_low, input imm_high,
                  input mem_byte, output ready);
endinterface

@@ design/c80se_out_if.sv @@
// Result channel: machine state after each instruction and the memory write.
interface c80se_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] pc_after;
  logic [7:0]  acc;
  logic [3:0]  flags_out;
  logic [15:0] bc_pair;
  logic [15:0] de_pair;
  logic [15:0] hl_pair;
  logic [15:0] stack_ptr;
  logic        mem_write;
  logic [7:0]  mem_data;
  logic        unimplemented;

  modport source (output valid, output pc_after, output acc, output flags_out,
                  output bc_pair, output de_pair, output hl_pair, output stack_ptr,
                  output mem_write, output mem_data, output unimplemented,
                  input ready);
  modport sink   (input valid, input pc_after, input acc, input flags_out,
                  input bc_pair, input de_pair, input hl_pair, input stack_ptr,
                  input mem_write, input mem_data, input unimplemented,
                  output ready);
endinterface

@@ design/c80se_exec.sv @@
// Decode and execute of one instruction against the current machine state.
module c80se_exec
  import c80se_pkg::*;
(
  input  instr_t instr_i,
  input  state_t cur_i,
  output state_t nxt_o,
  output exec_t  res_o
);

  logic [7:0]  func;
  logic [2:0]  opd_sel;
  logic [7:0]  opd;
  logic [7:0]  incdec;
  logic [15:0] pair;
  logic [15:0] hl;
  logic [16:0] dad_sum;
  logic [1:0]  alu_op;
  logic [7:0]  alu_v;
  logic        cin;
  logic [8:0]  alu_sum;
  logic        cond_flag;
  logic        taken;
  logic        pair_wr;
  logic [15:0] pair_val;
  logic        jump;
  logic [1:0]  len;
  state_t      nxt;
  exec_t       res;

  assign func    = instr_i.func;
  assign opd_sel = func[7] ? func[2:0] : func[5:3];
  assign hl      = {cur_i.h, cur_i.l};

  always_comb begin
    unique case (opd_sel)
      OPD_B:   opd = cur_i.b;
      OPD_C:   opd = cur_i.c;
      OPD_D:   opd = cur_i.d;
      OPD_E:   opd = cur_i.e;
      OPD_H:   opd = cur_i.h;
      OPD_L:   opd = cur_i.l;
      OPD_M:   opd = instr_i.mem_byte;
      OPD_A:   opd = cur_i.a;
      default: opd = cur_i.a;
    endcase
  end

  always_comb begin
    unique case (func[5:4])
      RP_BC:   pair = {cur_i.b, cur_i.c};
      RP_DE:   pair = {cur_i.d, cur_i.e};
      RP_HL:   pair = hl;
      RP_SP:   pair = cur_i.sp;
      default: pair = cur_i.sp;
    endcase
  end

  always_comb begin
    unique case (func[5:4])
      CC_Z:    cond_flag = cur_i.flags[FLAG_Z];
      CC_CY:   cond_flag = cur_i.flags[FLAG_CY];
      CC_P:    cond_flag = cur_i.flags[FLAG_P];
      CC_S:    cond_flag = cur_i.flags[FLAG_S];
      default: cond_flag = cur_i.flags[FLAG_S];
    endcase
  end

  assign taken   = func[3] ? cond_flag : ~cond_flag;
  assign incdec  = func[0] ? (opd - 8'd1) : (opd + 8'd1);
  assign dad_sum = {1'b0, hl} + {1'b0, pair};
  assign alu_op  = func[4:3];
  assign alu_v   = func[6] ? instr_i.imm_low : opd;
  assign cin     = alu_op[0] & cur_i.flags[FLAG_CY];
  assign alu_sum = alu_op[1] ? ({1'b0, cur_i.a} - {1'b0, alu_v} - {8'd0, cin})
                             : ({1'b0, cur_i.a} + {1'b0, alu_v} + {8'd0, cin});

  always_comb begin
    nxt      = cur_i;
    res      = '0;
    jump     = 1'b0;
    len      = 2'd1;
    pair_wr  = 1'b0;
    pair_val = pair;
    unique case (func) inside
      PAT_NOP: begin
      end
      PAT_INX: begin
        pair_wr  = 1'b1;
        pair_val = pair + 16'd1;
      end
      PAT_DCX: begin
        pair_wr  = 1'b1;
        pair_val = pair - 16'd1;
      end
      PAT_DAD: begin
        nxt.h              = dad_sum[15:8];
        nxt.l              = dad_sum[7:0];
        nxt.flags[FLAG_CY] = dad_sum[16];
      end
      PAT_INRDCR: begin
        nxt.flags = zsp_of(incdec) | {3'b000, cur_i.flags[FLAG_CY]};
        unique case (func[5:3])
          OPD_B:   nxt.b = incdec;
          OPD_C:   nxt.c = incdec;
          OPD_D:   nxt.d = incdec;
          OPD_E:   nxt.e = incdec;
          OPD_H:   nxt.h = incdec;
          OPD_L:   nxt.l = incdec;
          OPD_M: begin
            res.mem_write = 1'b1;
            res.mem_data  = incdec;
          end
          OPD_A:   nxt.a = incdec;
          default: nxt.a = incdec;
        endcase
      end
      PAT_ALU, OP_ADI, OP_ACI, OP_SUI: begin
        nxt.a     = alu_sum[7:0];
        nxt.flags = zsp_of(alu_sum[7:0]) | {3'b000, alu_sum[8]};
        if (func[6]) begin
          len = 2'd2;
        end
      end
      OP_JMP, OP_JMP_ALT: begin
        jump = 1'b1;
        len  = 2'd3;
      end
      PAT_JCC: begin
        jump = taken;
        len  = 2'd3;
      end
      default: res.unimplemented = 1'b1;
    endcase

    if (pair_wr) begin
      unique case (func[5:4])
        RP_BC:   {nxt.b, nxt.c} = pair_val;
        RP_DE:   {nxt.d, nxt.e} = pair_val;
        RP_HL:   {nxt.h, nxt.l} = pair_val;
        RP_SP:   nxt.sp = pair_val;
        default: nxt.sp = pair_val;
      endcase
    end

    if (!res.unimplemented) begin
      nxt.pc = jump ? {instr_i.imm_high, instr_i.imm_low} : (cur_i.pc + {14'd0, len});
    end
  end

  assign nxt_o = nxt;
  assign res_o = res;

endmodule

@@ design/cpu8080_subset_execute.sv @@
// Execute stage for a subset of 8080 instructions, with its architectural state.
// One instruction retires per cycle while the output is not stalled: an instruction
// is taken into the input register, executed against the current registers, SP, PC
// and flags, and its result lands in the output register at the same edge that
// updates the state, so the next instruction already sees the updated state. The
// single execute step that reads and writes the state sets this rate; a stalled output
// holds the result and the input register takes one more instruction before ready
// drops. After reset all architectural registers, SP, PC and flags are zero.
module cpu8080_subset_execute
  import c80se_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  c80se_in_if.sink          in_i,
  c80se_out_if.source       out_o
);

  logic   in_valid_q;
  instr_t instr_q;
  logic   out_valid_q;
  state_t out_state_q;
  exec_t  out_res_q;
  state_t state_q;
  state_t state_d;
  exec_t  exec_res;
  logic   fire;
  logic   in_accept;

  assign fire      = in_valid_q & (~out_valid_q | out_o.ready);
  assign in_i.ready = ~in_valid_q | fire;
  assign in_accept = in_i.valid & in_i.ready;

  c80se_exec u_exec (
    .instr_i (instr_q),
    .cur_i   (state_q),
    .nxt_o   (state_d),
    .res_o   (exec_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
    end else begin
      if (in_i.ready) begin
        in_valid_q <= in_i.valid;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
        state_q     <= state_d;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      instr_q <= '{func:     in_i.func,
                   imm_low:  in_i.imm_low,
                   imm_high: in_i.imm_high,
                   mem_byte: in_i.mem_byte};
    end
    if (fire) begin
      out_state_q <= state_d;
      out_res_q   <= exec_res;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.pc_after      = out_state_q.pc;
  assign out_o.acc           = out_state_q.a;
  assign out_o.flags_out     = out_state_q.flags;
  assign out_o.bc_pair       = {out_state_q.b, out_state_q.c};
  assign out_o.de_pair       = {out_state_q.d, out_state_q.e};
  assign out_o.hl_pair       = {out_state_q.h, out_state_q.l};
  assign out_o.stack_ptr     = out_state_q.sp;
  assign out_o.mem_write     = out_res_q.mem_write;
  assign out_o.mem_data      = out_res_q.mem_data;
  assign out_o.unimplemented = out_res_q.unimplemented;

endmodule

@@ design/c80se_checker.sv @@
// Port-level assertions for the 8080 subset execute block, bound to the top level.
module c80se_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [3:0] flags_i,
  input logic       mem_write_i,
  input logic [7:0] mem_data_i,
  input logic       unimplemented_i
);

  a_reset_idle: assert property (@(posedge clk_i) !rst_ni |-> !out_valid_i)
    else $error("result valid during reset");

  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("stalled result transaction dropped");

  a_wr_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !mem_write_i |-> mem_data_i == 8'h00)
    else $error("memory data without memory write");

  a_unimpl_no_wr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && unimplemented_i |-> !mem_write_i)
    else $error("unimplemented opcode wrote memory");

  a_wr_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && mem_write_i |->
      flags_i[2] == (mem_data_i == 8'h00) && flags_i[3] == mem_data_i[7] &&
      flags_i[1] == ~^mem_data_i)
    else $error("flags disagree with stored byte");

endmodule

bind cpu8080_subset_execute c80se_checker u_c80se_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .flags_i         (out_o.flags_out),
  .mem_write_i     (out_o.mem_write),
  .mem_data_i      (out_o.mem_data),
  .unimplemented_i (out_o.unimplemented)
);
